// ===== rtl/core/apt_pkg.sv =====
// Package for the altitude PID thrust block: widths, reset values, register
// indexes and the handshake types between the top level and the divider.
// Depends on nothing; every other file of the block but apt_check imports it.
package apt_pkg;

  // Default number of fraction bits of heights, speed, integral and power sum.
  localparam int FRAC_BITS_DEF = 16;

  // Fixed field and register widths.
  localparam int POS_W      = 32;  // heights and speed, signed
  localparam int COS_W      = 15;  // tilt cosine, Q1.14
  localparam int COS_SHIFT  = 14;  // fraction bits of the cosine
  localparam int GAIN_W     = 24;  // Q16.8 gains
  localparam int GAIN_FRAC  = 8;
  localparam int STEP_W     = 16;  // Q0.16 loop period
  localparam int LIM_W      = 26;  // integral clamp
  localparam int PWR_W      = 10;  // power in thousandths
  localparam int ACC_W      = 32;  // kept integral

  // Internal datapath widths.
  localparam int MUL_A_W    = 32;
  localparam int MUL_P_W    = MUL_A_W + GAIN_W;  // 56-bit product
  localparam int TERM_W     = 48;                // proportional and integral increment
  localparam int DAMP_W     = 47;                // damping magnitude
  localparam int INT_W      = 50;                // integral before clamping
  localparam int SUM_W      = 51;                // signed power sum
  localparam int MAG_W      = 49;                // saturated magnitude of the sum
  localparam int DVD_W      = MAG_W + COS_SHIFT; // dividend of the cosine divide

  // Saturation bound of the power sum, 2^48.
  localparam logic [MAG_W-1:0] SUM_SAT = {1'b1, {(MAG_W-1){1'b0}}};

  // Configuration port.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 26;

  localparam logic [CFG_IDX_W-1:0] REG_GAIN_PROP   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_INTEG  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_DAMP   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_TIME   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INTEG_LIMIT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_HOVER_POWER = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_POWER_MIN   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_POWER_MAX   = 3'd7;

  // Reset values of the configuration registers.
  localparam logic [GAIN_W-1:0] GAIN_PROP_RST   = 24'd138240;
  localparam logic [GAIN_W-1:0] GAIN_INTEG_RST  = 24'd256;
  localparam logic [GAIN_W-1:0] GAIN_DAMP_RST   = 24'd230400;
  localparam logic [STEP_W-1:0] STEP_TIME_RST   = 16'd262;
  localparam logic [LIM_W-1:0]  INTEG_LIMIT_RST = 26'd3276800;
  localparam logic [PWR_W-1:0]  HOVER_POWER_RST = 10'd500;
  localparam logic [PWR_W-1:0]  POWER_MIN_RST   = 10'd300;
  localparam logic [PWR_W-1:0]  POWER_MAX_RST   = 10'd800;

  // Input function codes.
  localparam logic FUNC_UPDATE = 1'b0;
  localparam logic FUNC_CLEAR  = 1'b1;

  // Request to the serial divider.
  typedef struct packed {
    logic             start;
    logic [COS_W-1:0] divisor;
  } div_req_t;

  // Status from the serial divider.
  typedef struct packed {
    logic done;
    logic overflow;
  } div_rsp_t;

endpackage

// ===== rtl/core/apt_if.sv =====
// Valid/ready channel interfaces of the altitude PID thrust block: the
// request channel carries one update or clear item, the response channel one thrust result.
// Depends on apt_pkg for the field widths.
interface apt_in_if import apt_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    func;
  logic signed [POS_W-1:0] target_height;
  logic signed [POS_W-1:0] measured_height;
  logic signed [POS_W-1:0] vertical_speed;
  logic [COS_W-1:0]        tilt_cosine;

  modport source (output valid, func, target_height, measured_height, vertical_speed,
                  tilt_cosine, input ready);
  modport sink   (input valid, func, target_height, measured_height, vertical_speed,
                  tilt_cosine, output ready);
endinterface

interface apt_out_if import apt_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PWR_W-1:0] power_permille;
  logic             clamped;

  modport source (output valid, power_permille, clamped, input ready);
  modport sink   (input valid, power_permille, clamped, output ready);
endinterface

// ===== rtl/core/apt_div.sv =====
// Serial restoring divider for the tilt compensation: one quotient bit per cycle,
// with an up-front check that flags quotients too large for QUOT_W bits.
// Depends on apt_pkg.
module apt_div import apt_pkg::*; #(
  parameter int QUOT_W = FRAC_BITS_DEF + PWR_W + 1
) (
  input  logic              clk,
  input  logic              rst,
  input  div_req_t          req,
  input  logic [DVD_W-1:0]  dividend,
  output div_rsp_t          rsp,
  output logic [QUOT_W-1:0] quotient
);

  localparam int CNT_W = $clog2(QUOT_W + 1);
  localparam int HI_W  = DVD_W - QUOT_W;

  logic              busy;
  logic              done;
  logic              ovf;
  logic [CNT_W-1:0]  cnt;
  logic [COS_W-1:0]  dvs;
  logic [COS_W-1:0]  rem;
  logic [QUOT_W-1:0] shreg;

  logic [HI_W-1:0]   head;
  logic              head_ovf;
  logic [COS_W:0]    trial;
  logic [COS_W:0]    diff;
  logic              take;

  // Upper dividend bits must stay below the divisor for the quotient to fit.
  assign head     = dividend[DVD_W-1:QUOT_W];
  assign head_ovf = head >= HI_W'(req.divisor);

  // One restoring step: shift in the next dividend bit and try a subtraction.
  assign trial = {rem, shreg[QUOT_W-1]};
  assign diff  = trial - {1'b0, dvs};
  assign take  = trial >= {1'b0, dvs};

  // Control: busy while iterating, done pulses for one cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      ovf  <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        ovf  <= head_ovf;
        busy <= !head_ovf;
        done <= head_ovf;
        cnt  <= CNT_W'(QUOT_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: the shift register holds the dividend low bits, then the quotient.
  always_ff @(posedge clk) begin
    if (req.start) begin
      dvs   <= req.divisor;
      rem   <= head[COS_W-1:0];
      shreg <= dividend[QUOT_W-1:0];
    end else if (busy) begin
      rem   <= take ? diff[COS_W-1:0] : trial[COS_W-1:0];
      shreg <= {shreg[QUOT_W-2:0], take};
    end
  end

  assign rsp.done     = done;
  assign rsp.overflow = ovf;
  assign quotient     = shreg;

endmodule

// ===== rtl/core/altitude_pid_thrust.sv =====
// Altitude PID thrust controller: a sequencer around one shared 32x24 multiplier
// and a serial divider. Depends on apt_pkg, apt_if and apt_div.
//
// An update transaction runs the absolute values, the multiply and add steps through
// the shared multiplier and the divide by the tilt cosine, which produces one quotient
// bit per cycle over FRAC_BITS + 11 bits. With a zero cosine the divide is skipped.
// The next request is taken only once the result has gone into the output register
// and the block is back in idle. A clear transaction zeroes the integral and gives
// no result. The result sits in an output register, so a new request is taken while
// a finished result still waits.
module altitude_pid_thrust import apt_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  apt_in_if.sink                request,
  apt_out_if.source             response
);

  localparam int QUOT_W = FRAC_BITS + PWR_W + 1;

  typedef enum logic [3:0] {
    S_IDLE, S_ABS, S_MUL_P, S_MUL_I, S_MUL_TL, S_MUL_TH, S_MUL_D,
    S_ADD_I, S_CLAMP_I, S_SUM_B, S_SUM_C, S_SAT, S_DIV, S_WAIT, S_FIN
  } state_t;

  state_t state;

  // Configuration registers.
  logic [GAIN_W-1:0] gain_prop;
  logic [GAIN_W-1:0] gain_integ;
  logic [GAIN_W-1:0] gain_damp;
  logic [STEP_W-1:0] step_time;
  logic [LIM_W-1:0]  integ_limit;
  logic [PWR_W-1:0]  hover_power;
  logic [PWR_W-1:0]  power_min;
  logic [PWR_W-1:0]  power_max;

  // Kept state and output register.
  logic signed [ACC_W-1:0] integ_acc;
  logic                    out_valid;
  logic [PWR_W-1:0]        out_power;
  logic                    out_clamped;

  // Working registers of one update.
  logic signed [POS_W:0]   err;
  logic signed [POS_W-1:0] spd;
  logic [COS_W-1:0]        cosv;
  logic [MUL_A_W-1:0]      err_mag;
  logic                    err_neg;
  logic [MUL_A_W-1:0]      spd_mag;
  logic                    spd_neg;
  logic [MUL_P_W-1:0]      prod;
  logic [TERM_W-1:0]       prop_mag;
  logic [STEP_W-1:0]       m1_hi;
  logic [TERM_W-1:0]       lo_prod;
  logic [TERM_W-1:0]       inc_mag;
  logic [DAMP_W-1:0]       damp_mag;
  logic signed [INT_W-1:0] integ_raw;
  logic signed [SUM_W-1:0] sum;
  logic                    sum_neg;
  logic                    sum_pos;
  logic [MAG_W-1:0]        mag;

  // Combinational helpers.
  logic                    in_acc;
  logic                    out_free;
  logic [MUL_A_W-1:0]      mul_a;
  logic [GAIN_W-1:0]       mul_b;
  logic [MUL_P_W-1:0]      mul_p;
  logic signed [INT_W-1:0] acc_ext;
  logic signed [INT_W-1:0] inc_s;
  logic signed [INT_W-1:0] lim_s;
  logic signed [ACC_W-1:0] integ_clamp;
  logic signed [SUM_W-1:0] prop_s;
  logic signed [SUM_W-1:0] damp_s;
  logic signed [SUM_W-1:0] hov_s;
  logic signed [SUM_W-1:0] acc_s;
  logic [SUM_W-1:0]        abs_sum;
  logic [QUOT_W-1:0]       lo_q;
  logic [QUOT_W-1:0]       hi_q;
  logic [PWR_W-1:0]        res_power;
  logic                    res_clamped;

  // Divider connection.
  div_req_t          div_req;
  div_rsp_t          div_rsp;
  logic [QUOT_W-1:0] quot;

  assign in_acc   = request.valid && request.ready;
  assign out_free = !out_valid || response.ready;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      gain_prop   <= GAIN_PROP_RST;
      gain_integ  <= GAIN_INTEG_RST;
      gain_damp   <= GAIN_DAMP_RST;
      step_time   <= STEP_TIME_RST;
      integ_limit <= INTEG_LIMIT_RST;
      hover_power <= HOVER_POWER_RST;
      power_min   <= POWER_MIN_RST;
      power_max   <= POWER_MAX_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_GAIN_PROP:   gain_prop   <= cfg_data[GAIN_W-1:0];
        REG_GAIN_INTEG:  gain_integ  <= cfg_data[GAIN_W-1:0];
        REG_GAIN_DAMP:   gain_damp   <= cfg_data[GAIN_W-1:0];
        REG_STEP_TIME:   step_time   <= cfg_data[STEP_W-1:0];
        REG_INTEG_LIMIT: integ_limit <= cfg_data[LIM_W-1:0];
        REG_HOVER_POWER: hover_power <= cfg_data[PWR_W-1:0];
        REG_POWER_MIN:   power_min   <= cfg_data[PWR_W-1:0];
        REG_POWER_MAX:   power_max   <= cfg_data[PWR_W-1:0];
        default: ;
      endcase
    end
  end

  // Shared multiplier operand selection.
  always_comb begin
    case (state)
      S_MUL_P: begin
        mul_a = err_mag;
        mul_b = gain_prop;
      end
      S_MUL_I: begin
        mul_a = err_mag;
        mul_b = gain_integ;
      end
      S_MUL_TL: begin
        mul_a = prod[GAIN_FRAC +: MUL_A_W];
        mul_b = GAIN_W'(step_time);
      end
      S_MUL_TH: begin
        mul_a = MUL_A_W'(m1_hi);
        mul_b = GAIN_W'(step_time);
      end
      S_MUL_D: begin
        mul_a = spd_mag;
        mul_b = gain_damp;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = MUL_P_W'(mul_a) * MUL_P_W'(mul_b);

  // Integral update and clamp to the symmetric limit.
  assign acc_ext = INT_W'(integ_acc);
  assign inc_s   = $signed({2'b00, inc_mag});
  assign lim_s   = $signed(INT_W'(integ_limit));

  always_comb begin
    if (integ_raw > lim_s) begin
      integ_clamp = ACC_W'(lim_s);
    end else if (integ_raw < -lim_s) begin
      integ_clamp = ACC_W'(-lim_s);
    end else begin
      integ_clamp = ACC_W'(integ_raw);
    end
  end

  // Terms of the power sum.
  assign prop_s  = $signed(SUM_W'(prop_mag));
  assign damp_s  = $signed(SUM_W'(damp_mag));
  assign hov_s   = $signed(SUM_W'({hover_power, {FRAC_BITS{1'b0}}}));
  assign acc_s   = SUM_W'(integ_acc);
  assign abs_sum = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);

  // Datapath registers, loaded step by step under the sequencer.
  always_ff @(posedge clk) begin
    prod <= mul_p;
    case (state)
      S_IDLE: begin
        if (in_acc) begin
          err  <= (POS_W+1)'(request.target_height) - (POS_W+1)'(request.measured_height);
          spd  <= request.vertical_speed;
          cosv <= request.tilt_cosine;
        end
      end
      S_ABS: begin
        err_neg <= err[POS_W];
        err_mag <= err[POS_W] ? MUL_A_W'(-err) : MUL_A_W'(err);
        spd_neg <= spd[POS_W-1];
        spd_mag <= spd[POS_W-1] ? MUL_A_W'(-spd) : MUL_A_W'(spd);
      end
      S_MUL_I: prop_mag <= prod[GAIN_FRAC +: TERM_W];
      S_MUL_TL: m1_hi <= prod[GAIN_FRAC+MUL_A_W +: STEP_W];
      S_MUL_TH: lo_prod <= prod[TERM_W-1:0];
      S_MUL_D: begin
        // High partial product lines up 16 bits above the dropped fraction.
        inc_mag <= {prod[MUL_A_W-1:0], {STEP_W{1'b0}}}
                 + TERM_W'(lo_prod[TERM_W-1:STEP_W]);
      end
      S_ADD_I: begin
        integ_raw <= err_neg ? acc_ext - inc_s : acc_ext + inc_s;
        sum       <= (err_neg ? -prop_s : prop_s) + hov_s;
        damp_mag  <= prod[GAIN_FRAC +: DAMP_W];
      end
      S_SUM_B: sum <= sum + acc_s;
      S_SUM_C: sum <= spd_neg ? sum + damp_s : sum - damp_s;
      S_SAT: begin
        sum_neg <= sum[SUM_W-1];
        sum_pos <= !sum[SUM_W-1] && (sum != '0);
        mag     <= (abs_sum > SUM_W'(SUM_SAT)) ? SUM_SAT : abs_sum[MAG_W-1:0];
      end
      default: ;
    endcase
  end

  // Divide the sum magnitude, scaled by 2^14, by the cosine.
  assign div_req.start   = (state == S_DIV) && (cosv != '0);
  assign div_req.divisor = cosv;

  apt_div #(
    .QUOT_W (QUOT_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .req      (div_req),
    .dividend ({mag, {COS_SHIFT{1'b0}}}),
    .rsp      (div_rsp),
    .quotient (quot)
  );

  // Window clamp of the compensated power; the lower bound is checked first.
  assign lo_q = QUOT_W'({power_min, {FRAC_BITS{1'b0}}});
  assign hi_q = QUOT_W'({power_max, {FRAC_BITS{1'b0}}});

  always_comb begin
    if (cosv == '0) begin
      res_power   = sum_pos ? power_max : power_min;
      res_clamped = 1'b1;
    end else if (sum_neg && (div_rsp.overflow || quot != '0)) begin
      res_power   = power_min;
      res_clamped = 1'b1;
    end else if (div_rsp.overflow) begin
      res_power   = power_max;
      res_clamped = 1'b1;
    end else if (quot < lo_q) begin
      res_power   = power_min;
      res_clamped = 1'b1;
    end else if (quot > hi_q) begin
      res_power   = power_max;
      res_clamped = 1'b1;
    end else begin
      res_power   = quot[FRAC_BITS +: PWR_W];
      res_clamped = 1'b0;
    end
  end

  // Sequencer, kept integral and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      integ_acc <= '0;
      out_valid <= 1'b0;
    end else begin
      if (response.valid && response.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_acc) begin
            if (request.func == FUNC_CLEAR) begin
              integ_acc <= '0;
            end else begin
              state <= S_ABS;
            end
          end
        end
        S_ABS:     state <= S_MUL_P;
        S_MUL_P:   state <= S_MUL_I;
        S_MUL_I:   state <= S_MUL_TL;
        S_MUL_TL:  state <= S_MUL_TH;
        S_MUL_TH:  state <= S_MUL_D;
        S_MUL_D:   state <= S_ADD_I;
        S_ADD_I:   state <= S_CLAMP_I;
        S_CLAMP_I: begin
          integ_acc <= integ_clamp;
          state     <= S_SUM_B;
        end
        S_SUM_B:   state <= S_SUM_C;
        S_SUM_C:   state <= S_SAT;
        S_SAT:     state <= S_DIV;
        S_DIV:     state <= (cosv == '0) ? S_FIN : S_WAIT;
        S_WAIT: begin
          if (div_rsp.done) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (out_free) begin
            out_valid   <= 1'b1;
            out_power   <= res_power;
            out_clamped <= res_clamped;
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign request.ready           = (state == S_IDLE);
  assign response.valid          = out_valid;
  assign response.power_permille = out_power;
  assign response.clamped        = out_clamped;

endmodule

// ===== rtl/core/apt_check.sv =====
// Port-level checks of the altitude PID thrust block and the bind that attaches
// them to the top level. Depends on the ports of altitude_pid_thrust only.
module apt_check (
  input logic       clk,
  input logic       rst,
  input logic       req_valid,
  input logic       req_ready,
  input logic       req_func,
  input logic       rsp_valid,
  input logic       rsp_ready,
  input logic [9:0] rsp_power,
  input logic       rsp_clamped
);

  // An update transaction occupies the block, which then stops taking requests.
  a_update_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && !req_func |=> !req_ready)
    else $error("request still ready right after an update transaction");

  // A clear transaction leaves the block ready for the next request and gives no result.
  a_clear_quick: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && req_func |=> req_ready)
    else $error("request not ready right after a clear transaction");

  // The block returns to idle only by posting a result.
  a_result_on_idle: assert property (@(posedge clk) disable iff (rst)
    $rose(req_ready) |-> rsp_valid)
    else $error("request ready rose without a result being posted");

  // A stalled result holds its payload.
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_power) && $stable(rsp_clamped))
    else $error("result changed or dropped while stalled");

endmodule

bind altitude_pid_thrust apt_check u_apt_check (
  .clk         (clk),
  .rst         (rst),
  .req_valid   (request.valid),
  .req_ready   (request.ready),
  .req_func    (request.func),
  .rsp_valid   (response.valid),
  .rsp_ready   (response.ready),
  .rsp_power   (response.power_permille),
  .rsp_clamped (response.clamped)
);

// ===== test/altitude_pid_thrust_tb.sv =====
// Self-checking testbench of the altitude PID thrust block: directed and random
// update and clear transactions, each result checked against a behavioral predictor.
// Depends on apt_pkg, apt_if and the altitude_pid_thrust RTL.
module altitude_pid_thrust_tb;
  import apt_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC = FRAC_BITS_DEF;
  localparam int IDLE_MAX = 19;
  localparam int DRAIN_CYCLES = 3 * (FRAC + 26);
  localparam int CYCLE_LIMIT = 700000;
  localparam int STALL_CYCLES = 400;
  localparam longint SUM_BOUND = 64'sd1 << 48;
  localparam longint COS_LEVEL = 64'sd1 << COS_SHIFT;
  localparam logic signed [POS_W-1:0] POS_MAX = 32'sh7FFFFFFF;
  localparam logic signed [POS_W-1:0] POS_MIN = 32'sh80000000;
  localparam logic [COS_W-1:0] COS_ONE = 15'd16384;
  localparam logic [COS_W-1:0] COS_TOP = 15'd32767;

  typedef struct packed {
    logic [PWR_W-1:0] power;
    logic             clamped;
  } thrust_t;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  apt_in_if  request_if ();
  apt_out_if response_if ();

  altitude_pid_thrust u_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .request  (request_if),
    .response (response_if)
  );

  // Predictor copy of the registers and the kept integral.
  longint unsigned   gain_prop_r   = GAIN_PROP_RST;
  longint unsigned   gain_integ_r  = GAIN_INTEG_RST;
  longint unsigned   gain_damp_r   = GAIN_DAMP_RST;
  longint unsigned   step_time_r   = STEP_TIME_RST;
  longint unsigned   integ_limit_r = INTEG_LIMIT_RST;
  longint unsigned   hover_power_r = HOVER_POWER_RST;
  longint unsigned   power_min_r   = POWER_MIN_RST;
  longint unsigned   power_max_r   = POWER_MAX_RST;
  logic signed [ACC_W-1:0] integ_state = '0;

  thrust_t expected_thrust[$];

  int  fail_count   = 0;
  int  updates_sent = 0;
  int  clears_sent  = 0;
  int  results_seen = 0;
  int  cfg_writes   = 0;
  int  cycle_count  = 0;
  int  stall_hold   = 0;
  bit  no_idle      = 1'b0;

  // Clock, cycle counter and timeout.
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("Timeout after %0d cycles with %0d results pending.", cycle_count,
             expected_thrust.size());
    $display("CHECK FAILED");
    $finish;
  end

  // Signed value times an unsigned Q16.8 gain, truncated toward zero.
  function automatic longint scale_by_gain(input longint x, input longint unsigned g);
    longint unsigned mag;
    mag = (x < 0) ? -x : x;
    mag = (mag * g) >> GAIN_FRAC;
    return (x < 0) ? -longint'(mag) : longint'(mag);
  endfunction

  // One control step: updates the integral and returns the thrust result.
  function automatic thrust_t predict_thrust(input logic signed [POS_W-1:0] th, mh, vs,
                                             input logic [COS_W-1:0] cosv);
    longint err, prop, inc, integ, lim, damp, sum, q, lo, hi;
    longint unsigned mag;
    thrust_t res;
    res.clamped = 1'b0;
    err  = longint'(th) - longint'(mh);
    prop = scale_by_gain(err, gain_prop_r);

    // Integral increment uses the error magnitude, then takes the sign back.
    mag = (err < 0) ? -err : err;
    mag = (mag * gain_integ_r) >> GAIN_FRAC;
    mag = (mag * step_time_r) >> 16;
    inc = (err < 0) ? -longint'(mag) : longint'(mag);
    lim = longint'(integ_limit_r);
    integ = longint'(integ_state) + inc;
    if (integ > lim) integ = lim;
    if (integ < -lim) integ = -lim;
    integ_state = integ[ACC_W-1:0];

    damp = scale_by_gain(longint'(vs), gain_damp_r);
    sum  = prop + integ - damp + longint'(hover_power_r << FRAC);
    if (sum > SUM_BOUND) sum = SUM_BOUND;
    if (sum < -SUM_BOUND) sum = -SUM_BOUND;

    lo = longint'(power_min_r << FRAC);
    hi = longint'(power_max_r << FRAC);
    if (cosv == '0) begin
      // A level of zero saturates on the sign of the sum.
      q = (sum > 0) ? hi : lo;
      res.clamped = 1'b1;
    end else begin
      q = (sum * COS_LEVEL) / longint'(cosv);
      if (q < lo) begin
        q = lo;
        res.clamped = 1'b1;
      end else if (q > hi) begin
        q = hi;
        res.clamped = 1'b1;
      end
    end
    res.power = q[FRAC +: PWR_W];
    return res;
  endfunction

  function automatic int unsigned pick_gap();
    return no_idle ? 0 : $urandom_range(0, IDLE_MAX);
  endfunction

  // Result checker: every response transaction against the oldest expectation.
  always @(posedge clk) begin : check_results
    thrust_t want;
    if (!rst && response_if.valid && response_if.ready) begin
      if (expected_thrust.size() == 0) begin
        fail_count++;
        $display("%0t: unexpected result power_permille %0d clamped %0b", $time,
                 response_if.power_permille, response_if.clamped);
      end else begin
        want = expected_thrust.pop_front();
        results_seen++;
        if (response_if.power_permille !== want.power) begin
          fail_count++;
          $display("%0t: power_permille expected %0d actual %0d", $time, want.power,
                   response_if.power_permille);
        end
        if (response_if.clamped !== want.clamped) begin
          fail_count++;
          $display("%0t: clamped expected %0b actual %0b", $time, want.clamped,
                   response_if.clamped);
        end
      end
    end
  end

  // Result receiver: random hold-off per transaction, plus a long stall on request.
  initial begin : drive_ready
    int unsigned gap;
    response_if.ready <= 1'b0;
    forever begin
      if (stall_hold > 0) begin
        gap = stall_hold;
        stall_hold = 0;
      end else begin
        gap = pick_gap();
      end
      if (gap > 0) begin
        response_if.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      response_if.ready <= 1'b1;
      do @(posedge clk); while (!response_if.valid);
    end
  end

  // Offers one request transaction and records its effect once accepted.
  task automatic send_item(input logic fn, input logic signed [POS_W-1:0] th, mh, vs,
                           input logic [COS_W-1:0] cosv);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      request_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    request_if.valid           <= 1'b1;
    request_if.func            <= fn;
    request_if.target_height   <= th;
    request_if.measured_height <= mh;
    request_if.vertical_speed  <= vs;
    request_if.tilt_cosine     <= cosv;
    do @(posedge clk); while (!request_if.ready);
    if (fn == FUNC_CLEAR) begin
      integ_state = '0;
      clears_sent++;
    end else begin
      expected_thrust.push_back(predict_thrust(th, mh, vs, cosv));
      updates_sent++;
    end
  endtask

  // Waits until every result is back and the block has had time to go quiet.
  task automatic wait_idle();
    request_if.valid <= 1'b0;
    while (expected_thrust.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    cfg_writes++;
    case (idx)
      REG_GAIN_PROP:   gain_prop_r   = value[GAIN_W-1:0];
      REG_GAIN_INTEG:  gain_integ_r  = value[GAIN_W-1:0];
      REG_GAIN_DAMP:   gain_damp_r   = value[GAIN_W-1:0];
      REG_STEP_TIME:   step_time_r   = value[STEP_W-1:0];
      REG_INTEG_LIMIT: integ_limit_r = value[LIM_W-1:0];
      REG_HOVER_POWER: hover_power_r = value[PWR_W-1:0];
      REG_POWER_MIN:   power_min_r   = value[PWR_W-1:0];
      REG_POWER_MAX:   power_max_r   = value[PWR_W-1:0];
      default: ;
    endcase
  endtask

  task automatic write_all_regs(input logic [CFG_DATA_W-1:0] value);
    write_reg(REG_GAIN_PROP, value);
    write_reg(REG_GAIN_INTEG, value);
    write_reg(REG_GAIN_DAMP, value);
    write_reg(REG_STEP_TIME, value);
    write_reg(REG_INTEG_LIMIT, value);
    write_reg(REG_HOVER_POWER, value);
    write_reg(REG_POWER_MIN, value);
    write_reg(REG_POWER_MAX, value);
  endtask

  // Mostly a plausible value, now and then zero or all ones of the field.
  function automatic logic [CFG_DATA_W-1:0] pick_reg_value(input int unsigned lo_val,
                                                           input int unsigned hi_val,
                                                           input int width);
    int unsigned r;
    r = $urandom_range(0, 7);
    if (r == 0) return '0;
    if (r == 1) return CFG_DATA_W'((64'd1 << width) - 1);
    return CFG_DATA_W'($urandom_range(lo_val, hi_val));
  endfunction

  task automatic load_random_gains();
    write_reg(REG_GAIN_PROP, pick_reg_value(0, 300000, GAIN_W));
    write_reg(REG_GAIN_INTEG, pick_reg_value(0, 8192, GAIN_W));
    write_reg(REG_GAIN_DAMP, pick_reg_value(0, 300000, GAIN_W));
    write_reg(REG_STEP_TIME, pick_reg_value(0, 4000, STEP_W));
    write_reg(REG_INTEG_LIMIT, pick_reg_value(0, 65536000, LIM_W));
    write_reg(REG_HOVER_POWER, pick_reg_value(0, 1000, PWR_W));
    write_reg(REG_POWER_MIN, pick_reg_value(0, 500, PWR_W));
    write_reg(REG_POWER_MAX, pick_reg_value(500, 1000, PWR_W));
  endtask

  // Mostly plausible flight values; the rest are raw fields and clears.
  task automatic send_random_item();
    int unsigned pick;
    int base;
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      send_item(FUNC_CLEAR, $urandom, $urandom, $urandom, COS_W'($urandom));
    end else if (pick < 28) begin
      send_item(FUNC_UPDATE, $urandom, $urandom, $urandom,
                (pick < 12) ? COS_W'(0) : COS_W'($urandom));
    end else begin
      base = int'($urandom_range(0, 2000000)) - 1000000;
      send_item(FUNC_UPDATE, base + int'($urandom_range(0, 80000)) - 40000, base,
                int'($urandom_range(0, 60000)) - 30000,
                COS_W'($urandom_range(9000, 16384)));
    end
  endtask

  // Reset register values: hover point, height and speed extremes, odd cosines.
  task automatic test_default_step();
    send_item(FUNC_UPDATE, 0, 0, 0, COS_ONE);
    send_item(FUNC_UPDATE, 65536, 0, 0, COS_ONE);
    send_item(FUNC_UPDATE, POS_MAX, POS_MIN, 0, COS_ONE);
    send_item(FUNC_UPDATE, POS_MIN, POS_MAX, 0, COS_ONE);
    send_item(FUNC_UPDATE, 0, 0, POS_MAX, COS_ONE);
    send_item(FUNC_UPDATE, 0, 0, POS_MIN, COS_TOP);
    send_item(FUNC_UPDATE, 1000, 0, -500, 15'd1);
  endtask

  // A zero cosine takes the upper bound on a positive sum, else the lower one.
  task automatic test_zero_cosine();
    send_item(FUNC_CLEAR, 0, 0, 0, '0);
    send_item(FUNC_UPDATE, 0, 0, 0, '0);
    send_item(FUNC_UPDATE, POS_MIN, POS_MAX, 0, '0);
  endtask

  // Drive the integral into both clamps, then clear it.
  task automatic test_integral_clamp();
    wait_idle();
    write_reg(REG_GAIN_INTEG, CFG_DATA_W'(24'hFFFFFF));
    write_reg(REG_STEP_TIME, CFG_DATA_W'(16'hFFFF));
    write_reg(REG_INTEG_LIMIT, CFG_DATA_W'(655360));
    send_item(FUNC_UPDATE, POS_MAX, 0, 0, COS_ONE);
    send_item(FUNC_UPDATE, POS_MAX, 0, 0, COS_ONE);
    send_item(FUNC_UPDATE, POS_MIN, 0, 0, COS_ONE);
    send_item(FUNC_CLEAR, POS_MAX, POS_MIN, POS_MAX, COS_TOP);
    send_item(FUNC_UPDATE, 0, 0, 0, COS_ONE);
  endtask

  // All registers at zero, all at ones, and an inverted output window.
  task automatic test_register_extremes();
    wait_idle();
    write_all_regs('0);
    send_item(FUNC_UPDATE, 0, 0, 0, '0);
    send_item(FUNC_UPDATE, 65536, 0, 0, COS_ONE);
    wait_idle();
    write_all_regs('1);
    send_item(FUNC_UPDATE, 1, 0, 0, COS_ONE);
    send_item(FUNC_UPDATE, 0, 0, -1, COS_TOP);
    wait_idle();
    write_all_regs('0);
    write_reg(REG_GAIN_PROP, CFG_DATA_W'(GAIN_PROP_RST));
    write_reg(REG_HOVER_POWER, CFG_DATA_W'(HOVER_POWER_RST));
    write_reg(REG_POWER_MIN, CFG_DATA_W'(900));
    write_reg(REG_POWER_MAX, CFG_DATA_W'(100));
    send_item(FUNC_UPDATE, 0, 0, 0, COS_ONE);
    send_item(FUNC_UPDATE, POS_MAX, 0, 0, COS_ONE);
  endtask

  // Random transactions over several random register settings.
  task automatic test_random_sweep();
    for (int phase = 0; phase < 8; phase++) begin
      wait_idle();
      load_random_gains();
      no_idle = (phase == 2 || phase == 5);
      repeat (110) send_random_item();
    end
    no_idle = 1'b0;
  endtask

  // Receiver stalls for a long stretch while requests keep coming back to back.
  task automatic test_output_stall();
    no_idle = 1'b1;
    stall_hold = STALL_CYCLES;
    repeat (20) send_random_item();
    no_idle = 1'b0;
  endtask

  initial begin
    rst                        <= 1'b1;
    cfg_we                     <= 1'b0;
    cfg_index                  <= REG_GAIN_PROP;
    cfg_data                   <= '0;
    request_if.valid           <= 1'b0;
    request_if.func            <= FUNC_UPDATE;
    request_if.target_height   <= '0;
    request_if.measured_height <= '0;
    request_if.vertical_speed  <= '0;
    request_if.tilt_cosine     <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    test_default_step();
    test_zero_cosine();
    test_integral_clamp();
    test_register_extremes();
    test_random_sweep();
    test_output_stall();
    wait_idle();

    $display("Ran %0d updates and %0d clears under %0d register writes; %0d results compared.",
             updates_sent, clears_sent, cfg_writes, results_seen);
    $display("Included zero and over-range cosines, clamped integrals and a long output stall.");
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/apt_pkg.sv
rtl/core/apt_if.sv
rtl/core/apt_div.sv
rtl/core/altitude_pid_thrust.sv
rtl/core/apt_check.sv
test/altitude_pid_thrust_tb.sv
